### rtl/core/ole_pkg.sv
package ole_pkg;

	// Node store geometry. The field widths of the request and result ports
	// are fixed at 32-bit values and 7-bit positions, so these stay constants.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int OP_W     = 3;
	localparam int ST_W     = 2;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// Request codes.
	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD  = 3'd0,
		OP_APPEND    = 3'd1,
		OP_INS_AFTER = 3'd2,
		OP_DELETE    = 3'd3,
		OP_SEARCH    = 3'd4
	} op_t;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD     = 2'd3;

	// Datapath actions, one per cycle.
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_START,
		ACT_STEP,
		ACT_MARK,
		ACT_INS_HEAD,
		ACT_APPEND_LINK,
		ACT_APPEND,
		ACT_INS_LINK,
		ACT_INS_AFTER,
		ACT_DELETE
	} act_t;

	typedef struct packed {
		act_t            act;
		logic            set_st;
		logic [ST_W-1:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            hit;
		logic            last;
		logic            pos_bad;
	} dp_sts_t;

endpackage

### rtl/core/ole_ctrl.sv
module ole_ctrl import ole_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_APPEND,
		S_INS_LINK,
		S_INS,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		state_d    = state_q;
		cmd.act    = ACT_NONE;
		cmd.set_st = 1'b0;
		cmd.st     = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.act = ACT_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (sts.op)
					OP_INS_HEAD, OP_APPEND: begin
						if (sts.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_FULL;
						end else if (sts.op == OP_INS_HEAD) begin
							cmd.act = ACT_INS_HEAD;
						end else if (sts.empty) begin
							cmd.act = ACT_APPEND;
						end else begin
							cmd.act = ACT_APPEND_LINK;
							state_d = S_APPEND;
						end
					end
					OP_INS_AFTER, OP_SEARCH: begin
						if (sts.empty) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_MISSING;
						end else begin
							cmd.act = ACT_START;
							state_d = S_WALK;
						end
					end
					OP_DELETE: begin
						if (sts.pos_bad) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_BAD;
						end else begin
							cmd.act = ACT_START;
							state_d = S_WALK;
						end
					end
					default: begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_BAD;
					end
				endcase
			end
			S_WALK: begin
				if (sts.hit) begin
					state_d = S_DONE;
					if (sts.op == OP_DELETE) begin
						cmd.act = ACT_DELETE;
					end else begin
						cmd.act = ACT_MARK;
						if (sts.op == OP_INS_AFTER) begin
							if (sts.full) begin
								cmd.set_st = 1'b1;
								cmd.st     = ST_FULL;
							end else begin
								state_d = S_INS_LINK;
							end
						end
					end
				end else if (sts.last) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_MISSING;
					state_d    = S_DONE;
				end else begin
					cmd.act = ACT_STEP;
				end
			end
			S_APPEND: begin
				cmd.act = ACT_APPEND;
				state_d = S_DONE;
			end
			S_INS_LINK: begin
				cmd.act = ACT_INS_LINK;
				state_d = S_INS;
			end
			S_INS: begin
				cmd.act = ACT_INS_AFTER;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_d == S_DONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

### rtl/core/ole_dp.sv
module ole_dp import ole_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  dp_cmd_t         cmd,
	input  logic [OP_W-1:0] op,
	input  value_t          item_value,
	input  value_t          anchor_key,
	input  cnt_t            target_position,
	output dp_sts_t         sts,
	output logic [ST_W-1:0] status,
	output logic            found,
	output cnt_t            match_position,
	output cnt_t            list_length
);

	// Node store and free stack.
	value_t node_values [CAPACITY];
	idx_t   node_links  [CAPACITY];
	idx_t   free_stack  [CAPACITY];

	// Latched request.
	logic [OP_W-1:0] op_q;
	value_t          item_q;
	value_t          key_q;
	cnt_t            target_q;

	// List state.
	idx_t head_q;
	idx_t tail_q;
	cnt_t count_q;
	cnt_t fs_top_q;
	cnt_t fresh_q;

	// Walk state.
	idx_t cur_q;
	idx_t prev_q;
	cnt_t pos_q;
	idx_t at_q;
	idx_t link_at_q;

	// Registered read data.
	value_t val_rd_q;
	idx_t   lnk_rd_q;
	idx_t   fs_rd_q;

	logic [ST_W-1:0] status_q;
	logic            found_q;
	cnt_t            mpos_q;

	idx_t   rd_addr;
	idx_t   new_node;
	idx_t   fs_rd_addr;
	logic   vw_en;
	logic   lw_en;
	idx_t   lw_addr;
	idx_t   lw_data;
	logic   fs_push;
	logic   fs_pop;

	// A recycled node comes off the free stack; otherwise the next untouched one.
	assign new_node   = (fs_top_q == '0) ? fresh_q[IDX_W-1:0] : fs_rd_q;
	assign fs_rd_addr = IDX_W'(fs_top_q - CNT_W'(1));
	assign rd_addr    = (cmd.act == ACT_STEP) ? lnk_rd_q : head_q;

	assign vw_en   = (cmd.act == ACT_INS_HEAD) || (cmd.act == ACT_APPEND) ||
	                 (cmd.act == ACT_INS_AFTER);
	assign fs_pop  = vw_en;
	assign fs_push = (cmd.act == ACT_DELETE);

	always_comb begin
		lw_en   = 1'b0;
		lw_addr = new_node;
		lw_data = head_q;
		case (cmd.act)
			ACT_INS_HEAD: begin
				lw_en = 1'b1;
			end
			ACT_APPEND: begin
				lw_en   = 1'b1;
				lw_data = '0;
			end
			ACT_APPEND_LINK: begin
				lw_en   = 1'b1;
				lw_addr = tail_q;
				lw_data = new_node;
			end
			ACT_INS_LINK: begin
				lw_en   = 1'b1;
				lw_addr = at_q;
				lw_data = new_node;
			end
			ACT_INS_AFTER: begin
				lw_en   = 1'b1;
				lw_data = link_at_q;
			end
			ACT_DELETE: begin
				lw_en   = (target_q != CNT_W'(1));
				lw_addr = prev_q;
				lw_data = lnk_rd_q;
			end
			default: begin
				lw_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_rd_q <= node_values[rd_addr];
		lnk_rd_q <= node_links[rd_addr];
		fs_rd_q  <= free_stack[fs_rd_addr];
		if (vw_en) begin
			node_values[new_node] <= item_q;
		end
		if (lw_en) begin
			node_links[lw_addr] <= lw_data;
		end
		if (fs_push) begin
			free_stack[fs_top_q[IDX_W-1:0]] <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.act == ACT_LOAD) begin
			op_q     <= op;
			item_q   <= item_value;
			key_q    <= (op == OP_INS_AFTER) ? anchor_key : item_value;
			target_q <= target_position;
		end
		case (cmd.act)
			ACT_START: begin
				cur_q <= head_q;
				pos_q <= CNT_W'(1);
			end
			ACT_STEP: begin
				prev_q <= cur_q;
				cur_q  <= lnk_rd_q;
				pos_q  <= pos_q + CNT_W'(1);
			end
			ACT_MARK: begin
				at_q      <= cur_q;
				link_at_q <= lnk_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			fs_top_q <= '0;
			fresh_q  <= '0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
			mpos_q   <= '0;
		end else begin
			if (fs_pop) begin
				if (fs_top_q == '0) begin
					fresh_q <= fresh_q + CNT_W'(1);
				end else begin
					fs_top_q <= fs_top_q - CNT_W'(1);
				end
			end
			if (cmd.act == ACT_LOAD) begin
				status_q <= ST_OK;
				found_q  <= 1'b0;
				mpos_q   <= '0;
			end
			if (cmd.set_st) begin
				status_q <= cmd.st;
			end
			case (cmd.act)
				ACT_MARK: begin
					found_q <= 1'b1;
					mpos_q  <= pos_q;
				end
				ACT_INS_HEAD: begin
					head_q  <= new_node;
					count_q <= count_q + CNT_W'(1);
					if (count_q == '0) begin
						tail_q <= new_node;
					end
				end
				ACT_APPEND: begin
					tail_q  <= new_node;
					count_q <= count_q + CNT_W'(1);
					if (count_q == '0) begin
						head_q <= new_node;
					end
				end
				ACT_INS_AFTER: begin
					count_q <= count_q + CNT_W'(1);
					if (at_q == tail_q) begin
						tail_q <= new_node;
					end
				end
				ACT_DELETE: begin
					fs_top_q <= fs_top_q + CNT_W'(1);
					count_q  <= count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (target_q == CNT_W'(1)) begin
						head_q <= lnk_rd_q;
					end else if (cur_q == tail_q) begin
						tail_q <= prev_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.op      = op_q;
	assign sts.full    = (count_q == CNT_W'(CAPACITY));
	assign sts.empty   = (count_q == '0);
	assign sts.hit     = (op_q == OP_DELETE) ? (pos_q == target_q) : (val_rd_q == key_q);
	assign sts.last    = (pos_q == count_q);
	assign sts.pos_bad = (target_q == '0) || (target_q > count_q);

	assign status         = status_q;
	assign found          = found_q;
	assign match_position = mpos_q;
	assign list_length    = count_q;

endmodule

### rtl/core/ordered_list_engine.sv
// Channel    Handshake          Fields
// request    start, busy        op, item_value, anchor_key, target_position
// result     done (strobe)      status, found, match_position, list_length
//
// A request is taken at a rising edge with start high and busy low. The result
// shows for exactly one cycle with done high; the receiver cannot hold it off.
// A transaction passes through a decode state, a walk step for each node visited
// through the registered link read, up to two store-write states, the result
// state and the idle state in which the next request is taken. The longest is an
// anchored insert after the tail of a 63-node list. Reset clears the list at once.

module ordered_list_engine import ole_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [OP_W-1:0] op,
	input  value_t          item_value,
	input  value_t          anchor_key,
	input  cnt_t            target_position,
	output logic            done,
	output logic [ST_W-1:0] status,
	output logic            found,
	output cnt_t            match_position,
	output cnt_t            list_length
);

	// The controller sequences each transaction: decode, list walk, and the
	// store writes. The datapath owns the node store, the free stack, the
	// head, tail and count registers, and the result registers.
	dp_cmd_t cmd;
	dp_sts_t sts;

	ole_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ole_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (op),
		.item_value      (item_value),
		.anchor_key      (anchor_key),
		.target_position (target_position),
		.sts             (sts),
		.status          (status),
		.found           (found),
		.match_position  (match_position),
		.list_length     (list_length)
	);

	// A result only ever follows a cycle in which the block was busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	// The list never grows past the node store.
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		list_length <= CNT_W'(CAPACITY))
		else $error("list length exceeds capacity");

	// The length only changes as a result is presented.
	a_len_changes_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(list_length) |-> done)
		else $error("list length changed outside a result cycle");

	// A match is reported only with ok or full status and a nonzero position.
	a_found_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> ((status == ST_OK || status == ST_FULL) &&
		                    (match_position != '0)))
		else $error("match reported with inconsistent status or position");

endmodule

### tb/sv/ordered_list_checker.sv
`timescale 1ns / 1ps

module ordered_list_checker import ole_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic [OP_W-1:0] op,
	input  value_t          item_value,
	input  value_t          anchor_key,
	input  cnt_t            target_position,
	input  logic            done,
	input  logic [ST_W-1:0] status,
	input  logic            found,
	input  cnt_t            match_position,
	input  cnt_t            list_length,
	output int              fail_count,
	output int              open_requests
);

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic            found;
		cnt_t            match_position;
		cnt_t            list_length;
	} reply_t;

	// Shadow copy of the node store, the free stack and the list pointers.
	logic [VALUE_W-1:0] node_value [CAPACITY];
	idx_t               node_link  [CAPACITY];
	idx_t               free_node  [CAPACITY];
	cnt_t               free_top;
	cnt_t               node_count;
	idx_t               head;
	idx_t               tail;

	reply_t predicted_replies [$];
	reply_t want;
	reply_t got;
	reply_t fresh;
	int     mismatches;

	task automatic clear_list();
		for (int i = 0; i < CAPACITY; i++) begin
			node_value[i] = '0;
			node_link[i]  = '0;
			free_node[i]  = idx_t'(i);
		end
		free_top   = cnt_t'(CAPACITY);
		node_count = '0;
		head       = '0;
		tail       = '0;
		predicted_replies.delete();
		mismatches = 0;
	endtask

	// Returns the 1-based position of the first node holding v, or zero.
	function automatic cnt_t locate(input logic [VALUE_W-1:0] v, output idx_t where);
		idx_t idx;
		idx   = head;
		where = '0;
		for (int p = 1; p <= node_count; p++) begin
			if (node_value[idx] == v) begin
				where = idx;
				return cnt_t'(p);
			end
			idx = node_link[idx];
		end
		return '0;
	endfunction

	task automatic grab_node(input logic [VALUE_W-1:0] v, output idx_t n);
		free_top = free_top - 1'b1;
		n = free_node[free_top[IDX_W-1:0]];
		node_value[n] = v;
	endtask

	task automatic drop_node(input idx_t n);
		if (free_top < CAPACITY) begin
			free_node[free_top[IDX_W-1:0]] = n;
			free_top = free_top + 1'b1;
		end
	endtask

	task automatic apply_list_request(input logic [OP_W-1:0] code, input value_t v,
			input value_t k, input cnt_t pos, output reply_t r);
		logic full;
		idx_t n;
		idx_t at;
		idx_t prev;
		idx_t victim;
		cnt_t hit;
		r = '0;
		r.status = ST_OK;
		full = (free_top == 0) || (node_count >= CAPACITY);
		case (code)
			OP_INS_HEAD: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					grab_node(v, n);
					node_link[n] = head;
					if (node_count == 0)
						tail = n;
					head = n;
					node_count = node_count + 1'b1;
				end
			end
			OP_APPEND: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					grab_node(v, n);
					node_link[n] = '0;
					if (node_count == 0)
						head = n;
					else
						node_link[tail] = n;
					tail = n;
					node_count = node_count + 1'b1;
				end
			end
			OP_INS_AFTER: begin
				hit = locate(k, at);
				if (hit == 0) begin
					r.status = ST_MISSING;
				end else begin
					r.found = 1'b1;
					r.match_position = hit;
					if (full) begin
						r.status = ST_FULL;
					end else begin
						grab_node(v, n);
						node_link[n]  = node_link[at];
						node_link[at] = n;
						if (at == tail)
							tail = n;
						node_count = node_count + 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (pos == 0 || pos > node_count) begin
					r.status = ST_BAD;
				end else begin
					if (pos == 1) begin
						victim = head;
						head = node_link[victim];
					end else begin
						prev = head;
						for (int s = 2; s < pos; s++)
							prev = node_link[prev];
						victim = node_link[prev];
						node_link[prev] = node_link[victim];
						if (victim == tail)
							tail = prev;
					end
					drop_node(victim);
					node_count = node_count - 1'b1;
					if (node_count == 0) begin
						head = '0;
						tail = '0;
					end
				end
			end
			OP_SEARCH: begin
				hit = locate(v, at);
				if (hit == 0) begin
					r.status = ST_MISSING;
				end else begin
					r.found = 1'b1;
					r.match_position = hit;
				end
			end
			default: r.status = ST_BAD;
		endcase
		r.list_length = node_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_list();
			fail_count    <= 0;
			open_requests <= 0;
		end else begin
			// A result is checked before a request taken at the same edge is predicted.
			if (done) begin
				got = {status, found, match_position, list_length};
				if (predicted_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request waiting: st=%0d f=%0d mp=%0d len=%0d",
							$realtime, got.status, got.found, got.match_position,
							got.list_length);
				end else begin
					want = predicted_replies.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch st %0d/%0d found %0d/%0d pos %0d/%0d len %0d/%0d (exp/act)",
								$realtime, want.status, got.status, want.found, got.found,
								want.match_position, got.match_position,
								want.list_length, got.list_length);
					end
				end
			end
			if (start && !busy) begin
				apply_list_request(op, item_value, anchor_key, target_position, fresh);
				predicted_replies.push_back(fresh);
			end
			fail_count    <= mismatches;
			open_requests <= predicted_replies.size();
		end
	end

endmodule

### tb/sv/ordered_list_engine_test.sv
`timescale 1ns / 1ps

module ordered_list_engine_test import ole_pkg::*;;

	// Request codes above the last defined operation; the block must refuse them.
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

	// Random stimulus volume, and the final stretch that runs without idling.
	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_TAIL   = 150;
	localparam int PHASE_LEN    = 120;

	// A quiet spell of this length is far longer than one transaction that walks
	// the most nodes, CAPACITY, plus the longest idle burst of the sender, so it
	// means the block has stopped answering.
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 80;

	typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_t;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [OP_W-1:0] op;
	value_t          item_value;
	value_t          anchor_key;
	cnt_t            target_position;
	logic            done;
	logic [ST_W-1:0] status;
	logic            found;
	cnt_t            match_position;
	cnt_t            list_length;

	int   fail_count;
	int   open_requests;
	int   quiet_cycles;
	cnt_t seen_length;

	ordered_list_engine DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.item_value      (item_value),
		.anchor_key      (anchor_key),
		.target_position (target_position),
		.done            (done),
		.status          (status),
		.found           (found),
		.match_position  (match_position),
		.list_length     (list_length)
	);

	// The checker sits on both channels, keeps its own model of the list and
	// compares every result with what that model predicts.
	ordered_list_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.item_value      (item_value),
		.anchor_key      (anchor_key),
		.target_position (target_position),
		.done            (done),
		.status          (status),
		.found           (found),
		.match_position  (match_position),
		.list_length     (list_length),
		.fail_count      (fail_count),
		.open_requests   (open_requests)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// The last reported length steers the choice of delete positions, so that
	// most deletes land inside the list. It may lag one transaction behind,
	// which only shifts the mix a little.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_length <= '0;
		else if (done)
			seen_length <= list_length;
	end

	// Watchdog: any cycle that accepts a request or delivers a result counts as
	// progress. A long spell without either ends the run as a failure.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Values are drawn mostly from a small pool, with the extremes of the signed
	// range in it, so that searches and anchor keys hit the list often. The rest
	// are fully random words, which toggle every bit.
	function automatic value_t pick_value();
		case ($urandom_range(0, 9))
			0: return value_t'(32'h8000_0000);
			1: return value_t'(32'h7fff_ffff);
			2: return '0;
			3: return '1;
			4, 5, 6: return value_t'(int'($urandom_range(0, 11)) - 4);
			default: return value_t'($urandom);
		endcase
	endfunction

	// Delete positions: mostly inside the list, sometimes at its two ends,
	// sometimes zero and sometimes past the end, up to the largest port value.
	function automatic cnt_t pick_position();
		int len;
		int r;
		len = int'(seen_length);
		r = $urandom_range(0, 99);
		if (r < 78)
			return cnt_t'(len > 0 ? $urandom_range(1, len) : 1);
		else if (r < 84)
			return cnt_t'(1);
		else if (r < 88)
			return cnt_t'(len);
		else if (r < 94)
			return '0;
		else
			return cnt_t'($urandom_range(len + 1, 127));
	endfunction

	// The operation mix depends on the phase: fill phases drive the list into
	// the full store, drain phases empty it again, mixed phases wander between.
	function automatic logic [OP_W-1:0] pick_op(input phase_t phase);
		int r;
		int head_end;
		int append_end;
		int after_end;
		int delete_end;
		r = $urandom_range(0, 99);
		case (phase)
			FILL_PHASE: begin
				head_end = 25; append_end = 50; after_end = 75; delete_end = 83;
			end
			DRAIN_PHASE: begin
				head_end = 6; append_end = 10; after_end = 14; delete_end = 84;
			end
			default: begin
				head_end = 18; append_end = 36; after_end = 54; delete_end = 74;
			end
		endcase
		if (r < head_end)
			return OP_INS_HEAD;
		else if (r < append_end)
			return OP_APPEND;
		else if (r < after_end)
			return OP_INS_AFTER;
		else if (r < delete_end)
			return OP_DELETE;
		else if (r < 95)
			return OP_SEARCH;
		else
			return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
	endfunction

	// Presents one request at the falling edge and returns once it has been
	// taken. Start stays high afterwards, so back-to-back requests need no
	// second assignment within the same time step.
	task automatic issue(input logic [OP_W-1:0] code, input value_t v, input value_t k,
			input cnt_t pos);
		@(negedge clk);
		start           = 1'b1;
		op              = code;
		item_value      = v;
		anchor_key      = k;
		target_position = pos;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drops start for a burst of idle cycles.
	task automatic hold_off(input int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		op              = OP_INS_HEAD;
		item_value      = '0;
		anchor_key      = '0;
		target_position = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed transactions, back to back. The empty list first: a search, a
		// delete and an anchored insert all have nothing to work on.
		issue(OP_SEARCH, '0, pick_value(), pick_position());
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(1));
		issue(OP_INS_AFTER, pick_value(), '0, pick_position());

		// Build MIN, 0, MAX, -1 using every insert flavor. The anchored insert
		// after the tail node must move the tail.
		issue(OP_INS_HEAD, value_t'(32'h8000_0000), pick_value(), pick_position());
		issue(OP_APPEND, value_t'(32'h7fff_ffff), pick_value(), pick_position());
		issue(OP_INS_AFTER, '1, value_t'(32'h7fff_ffff), pick_position());
		issue(OP_INS_AFTER, '0, value_t'(32'h8000_0000), pick_position());

		// Searches that hit the middle and the tail, and one that misses.
		issue(OP_SEARCH, value_t'(32'h7fff_ffff), pick_value(), pick_position());
		issue(OP_SEARCH, '1, pick_value(), pick_position());
		issue(OP_SEARCH, value_t'(12345), pick_value(), pick_position());

		// Bad positions: zero, the largest port value and one past the end.
		issue(OP_DELETE, pick_value(), pick_value(), '0);
		issue(OP_DELETE, pick_value(), pick_value(), '1);
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(5));

		// Delete the tail, then append so that a stale tail pointer would show.
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(4));
		issue(OP_APPEND, value_t'(7), pick_value(), pick_position());
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(2));
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(1));

		// Unused request codes change nothing.
		issue(OP_FIRST_UNUSED, pick_value(), pick_value(), pick_position());
		issue(OP_FIRST_UNUSED + 1'b1, pick_value(), pick_value(), pick_position());
		issue(OP_LAST_UNUSED, pick_value(), pick_value(), pick_position());

		// Shrink to a single node, delete it, and rebuild from the empty list.
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(2));
		issue(OP_DELETE, pick_value(), pick_value(), cnt_t'(1));
		issue(OP_APPEND, value_t'(42), pick_value(), pick_position());
		issue(OP_INS_HEAD, value_t'(43), pick_value(), pick_position());
		issue(OP_SEARCH, value_t'(42), pick_value(), pick_position());

		// Random transactions in rotating phases. Every field is random on every
		// request, also where the operation ignores it. Idle bursts fall at random
		// points of the block's walk; the final stretch runs without any.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			issue(pick_op(phase_t'((i / PHASE_LEN) % 3)), pick_value(), pick_value(),
				pick_position());
			if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0)
				hold_off($urandom_range(1, 18));
		end

		@(negedge clk);
		start = 1'b0;

		// Wait for the last results, then a little longer so that a stray extra
		// result would still be seen. The watchdog bounds both waits.
		while (open_requests != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
